[hdl/lort_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line offset remap table: shared definitions
// Sizes, the action codes and the request record that travels down the chain
// of table cells.
// ----------------------------------------------------------------------------
package lort_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned LINE_BITS   = 24;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned BL_W        = LINE_BITS + 1;
  localparam int unsigned OFF_W       = LINE_BITS + 2;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  // One request as it moves from cell to cell.
  typedef struct packed {
    logic                    vld;
    action_e                 act;
    logic                    full;
    logic [CNT_W-1:0]        cnt;
    logic [IDX_W-1:0]        widx;
    logic [BL_W-1:0]         line_a;
    logic signed [OFF_W-1:0] off_a;
    logic [BL_W-1:0]         line_b;
    logic signed [OFF_W-1:0] off_b;
    logic [LINE_BITS-1:0]    query;
    logic signed [OFF_W-1:0] off;
    logic                    done;
  } tok_t;

endpackage

[hdl/lort_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line offset remap table: request channel
// Valid/ready channel that carries one table action and its hunk or query.
// ----------------------------------------------------------------------------
interface lort_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     action;
  logic [lort_pkg::LINE_BITS-1:0] old_line;
  logic [lort_pkg::LINE_BITS-1:0] old_len;
  logic [lort_pkg::LINE_BITS-1:0] new_line;
  logic [lort_pkg::LINE_BITS-1:0] new_len;
  logic [lort_pkg::LINE_BITS-1:0] query_line;

  modport source (
    output valid, action, old_line, old_len, new_line, new_len, query_line,
    input  ready
  );
  modport sink (
    input  valid, action, old_line, old_len, new_line, new_len, query_line,
    output ready
  );
endinterface

[hdl/lort_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line offset remap table: response channel
// Valid/ready channel that carries the mapped line and the status flag.
// ----------------------------------------------------------------------------
interface lort_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [lort_pkg::OFF_W-1:0] mapped_line;
  logic                              status;

  modport source (
    output valid, mapped_line, status,
    input  ready
  );
  modport sink (
    input  valid, mapped_line, status,
    output ready
  );
endinterface

[hdl/lort_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line offset remap table: table cell
// Holds one breakpoint, takes writes for its slot and refines lookups that
// pass through it, then hands the request to the next cell.
// ----------------------------------------------------------------------------
module lort_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [lort_pkg::IDX_W-1:0] idx_i,
  input  lort_pkg::tok_t             tok_i,
  output lort_pkg::tok_t             tok_o
);

  logic [lort_pkg::BL_W-1:0]         line_q;
  logic signed [lort_pkg::OFF_W-1:0] off_q;
  lort_pkg::tok_t                    tok_q;
  lort_pkg::tok_t                    tok_d;
  logic                              add_ok;
  logic                              wr_a;
  logic                              wr_b;
  logic                              in_use;
  logic                              hit;
  logic                              past;

  assign add_ok = tok_i.vld && (tok_i.act == lort_pkg::ACT_ADD) && !tok_i.full;
  assign wr_a   = add_ok && (tok_i.widx == idx_i);
  assign wr_b   = add_ok && ((tok_i.widx + lort_pkg::IDX_W'(1)) == idx_i);

  // Slots at or beyond the fill count hold stale data and are skipped.
  assign in_use = lort_pkg::CNT_W'(idx_i) < tok_i.cnt;
  assign hit    = (tok_i.act == lort_pkg::ACT_LOOKUP) && !tok_i.done && in_use;
  assign past   = line_q > {1'b0, tok_i.query};

  always_comb begin
    tok_d = tok_i;
    if (hit) begin
      if (past) begin
        tok_d.done = 1'b1;
      end else begin
        tok_d.off = off_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && wr_a) begin
      line_q <= tok_i.line_a;
      off_q  <= tok_i.off_a;
    end else if (en_i && wr_b) begin
      line_q <= tok_i.line_b;
      off_q  <= tok_i.off_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (en_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

[hdl/lort_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line offset remap table: output stage
// Adds the selected offset to the query with saturation for lookups and holds
// the response until it is taken. Its free state sets the advance of the chain.
// ----------------------------------------------------------------------------
module lort_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lort_pkg::tok_t  tok_i,
  output logic            adv_o,
  lort_rsp_if.source      rsp_o
);

  logic signed [lort_pkg::OFF_W:0]   sum;
  logic signed [lort_pkg::OFF_W-1:0] sat;
  logic signed [lort_pkg::OFF_W-1:0] mapped_d;
  logic signed [lort_pkg::OFF_W-1:0] mapped_q;
  logic                              status_d;
  logic                              status_q;
  logic                              vld_q;

  assign sum = $signed({3'b000, tok_i.query}) + $signed({tok_i.off[lort_pkg::OFF_W-1], tok_i.off});

  // The two top bits differ exactly when the sum left the output range.
  always_comb begin
    if (sum[lort_pkg::OFF_W] != sum[lort_pkg::OFF_W-1]) begin
      sat = sum[lort_pkg::OFF_W] ? {1'b1, {(lort_pkg::OFF_W-1){1'b0}}}
                                 : {1'b0, {(lort_pkg::OFF_W-1){1'b1}}};
    end else begin
      sat = sum[lort_pkg::OFF_W-1:0];
    end
  end

  assign mapped_d = (tok_i.act == lort_pkg::ACT_LOOKUP) ? sat : '0;
  assign status_d = (tok_i.act == lort_pkg::ACT_ADD) && tok_i.full;
  assign adv_o    = !vld_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_o) begin
      vld_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      mapped_q <= mapped_d;
      status_q <= status_d;
    end
  end

  assign rsp_o.valid       = vld_q;
  assign rsp_o.mapped_line = mapped_q;
  assign rsp_o.status      = status_q;

endmodule

[hdl/line_offset_remap_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line offset remap table: top level
// Ordered table of breakpoints built from diff hunks, answering old-to-new
// line lookups through a chain of table cells.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake        Payload
//   req_i    in         valid / ready    action, old_line, old_len, new_line,
//                                        new_len, query_line
//   rsp_o    out        valid / ready    mapped_line, status
//
// Every request enters the chain and walks the row of MAX_ENTRIES - 1 cells,
// one cell per cycle while the chain advances, and the output stage then
// registers its response. One request is taken in every cycle unless the
// response register stalls the chain, so the sustained rate is one request per cycle.
// Reset empties the table down to its fixed first entry (line 0, offset 0);
// no clearing pass is needed. When the response register holds an untaken
// response, the whole chain stops and req_i.ready falls in the same cycle.
// ----------------------------------------------------------------------------
module line_offset_remap_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  lort_req_if.sink    req_i,
  lort_rsp_if.source  rsp_o
);

  localparam int unsigned IdxW = lort_pkg::IDX_W;

  // The first entry never changes, so it lives here as the starting offset of
  // every lookup. The head keeps the fill count; the cells keep entries one
  // and up. Each request carries the fill count it saw on entry, so every
  // cell sees writes and lookups in request order.
  logic [lort_pkg::CNT_W-1:0] count_q;
  logic [lort_pkg::CNT_W-1:0] count_d;
  logic                       adv;
  logic                       acc;
  logic                       full;
  lort_pkg::action_e          act;
  logic [lort_pkg::BL_W-1:0]  sum_old;
  logic [lort_pkg::BL_W-1:0]  sum_new;
  lort_pkg::tok_t             chain [lort_pkg::MAX_ENTRIES];

  assign act  = lort_pkg::action_e'(req_i.action);
  assign acc  = req_i.valid && req_i.ready;
  assign full = count_q > lort_pkg::CNT_W'(lort_pkg::MAX_ENTRIES - 2);

  // End line of the hunk on each side; the second offset is their difference.
  assign sum_old = {1'b0, req_i.old_line} + {1'b0, req_i.old_len};
  assign sum_new = {1'b0, req_i.new_line} + {1'b0, req_i.new_len};

  always_comb begin
    chain[0]        = '0;
    chain[0].vld    = req_i.valid;
    chain[0].act    = act;
    chain[0].full   = full;
    chain[0].cnt    = count_q;
    chain[0].widx   = count_q[IdxW-1:0];
    chain[0].line_a = {1'b0, req_i.old_line};
    chain[0].off_a  = {2'b00, req_i.new_line} - {2'b00, req_i.old_line};
    chain[0].line_b = sum_old;
    chain[0].off_b  = {1'b0, sum_new} - {1'b0, sum_old};
    chain[0].query  = req_i.query_line;
    chain[0].off    = '0;
    chain[0].done   = 1'b0;
  end

  // A clear only resets the fill count; stale cells are then out of range.
  always_comb begin
    count_d = count_q;
    if (acc) begin
      case (act)
        lort_pkg::ACT_CLEAR: begin
          count_d = lort_pkg::CNT_W'(1);
        end
        lort_pkg::ACT_ADD: begin
          if (!full) begin
            count_d = count_q + lort_pkg::CNT_W'(2);
          end
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= lort_pkg::CNT_W'(1);
    end else begin
      count_q <= count_d;
    end
  end

  for (genvar k = 1; k < lort_pkg::MAX_ENTRIES; k++) begin : g_cell
    lort_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .idx_i  (IdxW'(k)),
      .tok_i  (chain[k-1]),
      .tok_o  (chain[k])
    );
  end

  lort_out u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (chain[lort_pkg::MAX_ENTRIES-1]),
    .adv_o  (adv),
    .rsp_o  (rsp_o)
  );

  assign req_i.ready = adv;

  // The table grows two entries at a time from one, so the count stays odd.
  a_count_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q[0] == 1'b1)
    else $error("fill count is even");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lort_pkg::CNT_W'(lort_pkg::MAX_ENTRIES))
    else $error("fill count beyond table size");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (act == lort_pkg::ACT_ADD) && full |=> count_q == $past(count_q))
    else $error("refused add changed the table");

  a_add_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (act == lort_pkg::ACT_ADD) && !full
    |=> count_q == $past(count_q) + lort_pkg::CNT_W'(2))
    else $error("accepted add did not append two entries");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> rsp_o.valid && !rsp_o.ready)
    else $error("chain stalled without a waiting response");

endmodule
